/* hdl/egb_pkg.sv */
// Shared types and constants for the extended gcd / Bezout coefficient block.
package egb_pkg;

    // Default operand width handed to the top level
    localparam int OPERAND_BITS_DEF = 31;

    // Fixed field widths of the transfer payloads
    localparam int IN_W    = 31;
    localparam int GCD_W   = 31;
    localparam int COEFF_W = 32;

    // Input transfer payload
    typedef struct packed {
        logic [IN_W-1:0] first_operand;
        logic [IN_W-1:0] second_operand;
    } in_t;

    // Result transfer payload
    typedef struct packed {
        logic [GCD_W-1:0]          gcd_value;
        logic signed [COEFF_W-1:0] coeff_larger;
        logic signed [COEFF_W-1:0] coeff_smaller;
        logic                      operands_swapped;
    } out_t;

    // Sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

/* hdl/egb_step.sv */
// Shared shift-compare-subtract unit: one quotient bit of a division step.
module egb_step #(
    parameter int OPERAND_BITS = egb_pkg::OPERAND_BITS_DEF,
    parameter int KW           = 5
) (
    input  logic [OPERAND_BITS-1:0]    a,
    input  logic [OPERAND_BITS-1:0]    b,
    input  logic [KW-1:0]              k,
    input  logic [egb_pkg::COEFF_W-1:0] xa,
    input  logic [egb_pkg::COEFF_W-1:0] xb,
    input  logic [egb_pkg::COEFF_W-1:0] ya,
    input  logic [egb_pkg::COEFF_W-1:0] yb,
    output logic [OPERAND_BITS-1:0]    rem,
    output logic [egb_pkg::COEFF_W-1:0] x_new,
    output logic [egb_pkg::COEFF_W-1:0] y_new
);

    localparam int WW = 2 * OPERAND_BITS;

    logic [WW-1:0]                 b_wide;
    logic [WW-1:0]                 a_wide;
    logic                          fits;
    logic [egb_pkg::COEFF_W-1:0]   x_sh;
    logic [egb_pkg::COEFF_W-1:0]   y_sh;

    // Align the divisor at bit k and test whether it fits in the partial remainder
    assign b_wide = {{OPERAND_BITS{1'b0}}, b} << k;
    assign a_wide = {{OPERAND_BITS{1'b0}}, a};
    assign fits   = (b_wide <= a_wide);

    // Subtract the aligned divisor and the matching coefficient multiples
    assign x_sh  = xb << k;
    assign y_sh  = yb << k;
    assign rem   = fits ? (a - b_wide[OPERAND_BITS-1:0]) : a;
    assign x_new = fits ? (xa - x_sh) : xa;
    assign y_new = fits ? (ya - y_sh) : ya;

endmodule

/* hdl/extended_gcd_bezout.sv */
// Top level: sequencer and registers of the extended Euclidean algorithm.
// Each quotient step runs the shared shift-subtract unit once per quotient bit, MSB first.
// Throughput: one item at a time; busy stays high from transfer until the result strobe.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops done.
module extended_gcd_bezout #(
    parameter int OPERAND_BITS = egb_pkg::OPERAND_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  egb_pkg::in_t  operands,
    output logic          done,
    output egb_pkg::out_t result
);

    localparam int N   = OPERAND_BITS;
    localparam int KW  = (N > 1) ? $clog2(N) : 1;
    localparam int CW  = egb_pkg::COEFF_W;
    localparam int EXT = N + egb_pkg::IN_W;
    localparam int GX  = N + egb_pkg::GCD_W;
    localparam logic [KW-1:0] K_TOP = KW'(N - 1);

    egb_pkg::state_t state_reg, state_next;

    logic [KW-1:0]  k_reg;
    logic [N-1:0]   a_reg, b_reg;
    logic [CW-1:0]  xa_reg, xb_reg, ya_reg, yb_reg;
    logic           swapped_reg;
    logic           done_reg;
    egb_pkg::out_t  result_reg;

    logic           load, step, last, finish;
    logic [EXT-1:0] first_ext, second_ext;
    logic [N-1:0]   op_first, op_second;
    logic           do_swap;
    logic [N-1:0]   rem;
    logic [CW-1:0]  x_new, y_new;
    logic [GX-1:0]  gcd_ext;

    // Fit the operands to the working width
    assign first_ext  = {{N{1'b0}}, operands.first_operand};
    assign second_ext = {{N{1'b0}}, operands.second_operand};
    assign op_first   = first_ext[N-1:0];
    assign op_second  = second_ext[N-1:0];
    assign do_swap    = (op_first < op_second);

    // Shared division step unit
    egb_step #(
        .OPERAND_BITS (N),
        .KW           (KW)
    ) u_step (
        .a     (a_reg),
        .b     (b_reg),
        .k     (k_reg),
        .xa    (xa_reg),
        .xb    (xb_reg),
        .ya    (ya_reg),
        .yb    (yb_reg),
        .rem   (rem),
        .x_new (x_new),
        .y_new (y_new)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            egb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = egb_pkg::ST_RUN;
                end
            end
            egb_pkg::ST_RUN:
            begin
                if (b_reg == '0)
                begin
                    state_next = egb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = egb_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        load   = 1'b0;
        step   = 1'b0;
        last   = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            egb_pkg::ST_IDLE:
            begin
                load = start;
            end
            egb_pkg::ST_RUN:
            begin
                finish = (b_reg == '0);
                step   = (b_reg != '0);
                last   = (b_reg != '0) && (k_reg == '0);
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= egb_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
        end
    end

    // Operand, coefficient and bit counter registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg       <= do_swap ? op_second : op_first;
            b_reg       <= do_swap ? op_first : op_second;
            xa_reg      <= CW'(1);
            xb_reg      <= '0;
            ya_reg      <= '0;
            yb_reg      <= CW'(1);
            k_reg       <= K_TOP;
            swapped_reg <= do_swap;
        end
        else if (step)
        begin
            if (last)
            begin
                // advance to the next remainder pair
                a_reg  <= b_reg;
                b_reg  <= rem;
                xa_reg <= xb_reg;
                xb_reg <= x_new;
                ya_reg <= yb_reg;
                yb_reg <= y_new;
                k_reg  <= K_TOP;
            end
            else
            begin
                a_reg  <= rem;
                xa_reg <= x_new;
                ya_reg <= y_new;
                k_reg  <= k_reg - KW'(1);
            end
        end
    end

    // Hold the result for its one-cycle transfer
    assign gcd_ext = {{egb_pkg::GCD_W{1'b0}}, a_reg};

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            result_reg.gcd_value        <= gcd_ext[egb_pkg::GCD_W-1:0];
            result_reg.coeff_larger     <= xa_reg;
            result_reg.coeff_smaller    <= ya_reg;
            result_reg.operands_swapped <= swapped_reg;
        end
    end

    assign busy   = (state_reg != egb_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Result strobe only comes once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == egb_pkg::ST_IDLE))
        else $error("result strobe while sequencer busy");

    // An accepted transfer makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not start the sequencer");

    // A zero divisor while running finishes the item
    a_zero_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == egb_pkg::ST_RUN) && (b_reg == '0)) |=> done_reg)
        else $error("zero divisor did not produce a result");

    // Bit counter stays within the operand width
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == egb_pkg::ST_RUN) |-> (k_reg <= K_TOP))
        else $error("quotient bit counter out of range");

endmodule
